### rtl/tq_pkg.sv
// Shared types and constants for the timed event queue.
// No dependencies; imported by tq_cell and timed_event_queue.
package tq_pkg;

  localparam int TIME_W        = 48;
  localparam int IV_W          = 32;
  localparam int SLOTS_DEF     = 16;
  localparam int ID_WIDTH_DEF  = 32;
  localparam int TAG_WIDTH_DEF = 16;
  localparam int ID_MAX_W      = 64;
  localparam int TAG_MAX_W     = 32;
  localparam int IDX_MAX_W     = 8;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_ADD_REL    = 3'd1;
  localparam logic [2:0] CMD_ADD_ABS    = 3'd2;
  localparam logic [2:0] CMD_CANCEL_ID  = 3'd3;
  localparam logic [2:0] CMD_CANCEL_TAG = 3'd4;
  localparam logic [2:0] CMD_SET_IV     = 3'd5;
  localparam logic [2:0] CMD_CLEAR      = 3'd6;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  // command broadcast to every cell, held stable while a wave runs
  typedef struct packed {
    logic [2:0]           cmd;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    dl_new;
    logic [IV_W-1:0]      iv;
    logic                 rep;
    logic [TAG_MAX_W-1:0] own;
    logic [TAG_MAX_W-1:0] sig;
    logic [ID_MAX_W-1:0]  id;
  } bcast_t;

  // wave control passed from cell to cell
  typedef struct packed {
    logic v;
    logic found;
  } ctl_t;

  // commit of one fired slot
  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
  } fire_t;

endpackage

### rtl/tq_cell.sv
// One timer slot of the chain: holds the slot state and updates the passing wave.
// Depends on tq_pkg.
module tq_cell
  import tq_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int IDX_W     = 4,
  parameter int ID_WIDTH  = ID_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcast_t               bc,
  input  fire_t                fire,
  input  ctl_t                 ci,
  input  logic [TIME_W-1:0]    dl_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [ID_WIDTH-1:0]  id_i,
  input  logic [TAG_WIDTH-1:0] own_i,
  input  logic [TAG_WIDTH-1:0] sig_i,
  output ctl_t                 co,
  output logic [TIME_W-1:0]    dl_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [ID_WIDTH-1:0]  id_o,
  output logic [TAG_WIDTH-1:0] own_o,
  output logic [TAG_WIDTH-1:0] sig_o
);

  logic                 valid_r, valid_nxt;
  logic [TIME_W-1:0]    dl_r, dl_nxt;
  logic [IV_W-1:0]      iv_r, iv_nxt;
  logic                 rep_r, rep_nxt;
  logic [TAG_WIDTH-1:0] own_r, own_nxt;
  logic [TAG_WIDTH-1:0] sig_r, sig_nxt;
  logic [ID_WIDTH-1:0]  id_r, id_nxt;

  ctl_t                 co_r, co_nxt;
  logic [TIME_W-1:0]    wdl_r, wdl_nxt;
  logic [IDX_W-1:0]     widx_r, widx_nxt;
  logic [ID_WIDTH-1:0]  wid_r, wid_nxt;
  logic [TAG_WIDTH-1:0] wown_r, wown_nxt;
  logic [TAG_WIDTH-1:0] wsig_r, wsig_nxt;

  logic [ID_WIDTH-1:0]  cmd_id;
  logic [TAG_WIDTH-1:0] cmd_own, cmd_sig;
  logic                 hit_id, hit_tag, expired;
  logic [TIME_W:0]      rearm_sum;
  logic [TIME_W-1:0]    rearm_dl;

  assign cmd_id  = bc.id[ID_WIDTH-1:0];
  assign cmd_own = bc.own[TAG_WIDTH-1:0];
  assign cmd_sig = bc.sig[TAG_WIDTH-1:0];
  assign hit_id  = valid_r && (id_r == cmd_id);
  assign hit_tag = valid_r && (own_r == cmd_own) && (sig_r == cmd_sig);
  assign expired = valid_r && (dl_r < bc.now);

  assign rearm_sum = {1'b0, bc.now} + {{(TIME_W + 1 - IV_W){1'b0}}, iv_r};
  assign rearm_dl  = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

  always_comb begin
    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    iv_nxt    = iv_r;
    rep_nxt   = rep_r;
    own_nxt   = own_r;
    sig_nxt   = sig_r;
    id_nxt    = id_r;
    // wave payload holds once the wave has passed, so the chain end keeps it
    co_nxt    = co_r;
    co_nxt.v  = ci.v;
    wdl_nxt   = wdl_r;
    widx_nxt  = widx_r;
    wid_nxt   = wid_r;
    wown_nxt  = wown_r;
    wsig_nxt  = wsig_r;
    if (ci.v) begin
      co_nxt.found = ci.found;
      wdl_nxt      = dl_i;
      widx_nxt     = idx_i;
      wid_nxt      = id_i;
      wown_nxt     = own_i;
      wsig_nxt     = sig_i;
      case (bc.cmd)
        CMD_TICK: begin
          if (expired && (!ci.found || (dl_r < dl_i))) begin
            co_nxt.found = 1'b1;
            wdl_nxt      = dl_r;
            widx_nxt     = IDX_W'(IDX);
            wid_nxt      = id_r;
            wown_nxt     = own_r;
            wsig_nxt     = sig_r;
          end
        end
        CMD_ADD_REL, CMD_ADD_ABS: begin
          if (!valid_r && !ci.found) begin
            co_nxt.found = 1'b1;
            valid_nxt    = 1'b1;
            dl_nxt       = bc.dl_new;
            own_nxt      = cmd_own;
            sig_nxt      = cmd_sig;
            id_nxt       = cmd_id;
            iv_nxt       = (bc.cmd == CMD_ADD_REL) ? bc.iv : '0;
            rep_nxt      = (bc.cmd == CMD_ADD_REL) ? bc.rep : 1'b0;
          end
        end
        CMD_CANCEL_ID: begin
          if (hit_id && !ci.found) begin
            co_nxt.found = 1'b1;
            valid_nxt    = 1'b0;
          end
        end
        CMD_CANCEL_TAG: begin
          if (hit_tag) begin
            co_nxt.found = 1'b1;
            valid_nxt    = 1'b0;
          end
        end
        CMD_SET_IV: begin
          if (hit_id && !ci.found) begin
            co_nxt.found = 1'b1;
            iv_nxt       = bc.iv;
            dl_nxt       = bc.dl_new;
          end
        end
        CMD_CLEAR: begin
          co_nxt.found = 1'b1;
          valid_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
    // fired slot: re-arm or free
    if (fire.en && (fire.idx[IDX_W-1:0] == IDX_W'(IDX))) begin
      if (rep_r) begin
        dl_nxt = rearm_dl;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      co_r.v  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      co_r.v  <= co_nxt.v;
    end
    co_r.found <= co_nxt.found;
    dl_r       <= dl_nxt;
    iv_r       <= iv_nxt;
    rep_r      <= rep_nxt;
    own_r      <= own_nxt;
    sig_r      <= sig_nxt;
    id_r       <= id_nxt;
    wdl_r      <= wdl_nxt;
    widx_r     <= widx_nxt;
    wid_r      <= wid_nxt;
    wown_r     <= wown_nxt;
    wsig_r     <= wsig_nxt;
  end

  assign co    = co_r;
  assign dl_o  = wdl_r;
  assign idx_o = widx_r;
  assign id_o  = wid_r;
  assign own_o = wown_r;
  assign sig_o = wsig_r;

endmodule

### rtl/timed_event_queue.sv
// Top level of the timed event queue: command front end, wave sequencer, result register.
// Depends on tq_pkg and tq_cell.
//
// A table of SLOTS timers kept in a chain of cells, one slot per cell. Every
// command launches a wave that travels down the chain one cell per clock;
// each cell acts on the command as the wave passes (lowest free slot for an
// add, lowest matching id for cancel and set interval, every match for cancel
// by owner and signal, all slots for clear). A command ends once the result
// register is free. A tick runs one wave per fired timer, and a last wave that
// finds none, to find the earliest expired deadline (ties to the lower slot),
// commits it (re-arm or free) and starts the next wave. One item is worked on
// at a time; in_tready is high only while the block is idle. Results leave
// through a single output register, so the next result of a tick waits while
// the current one is not taken.
module timed_event_queue
  import tq_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // bits from 0: now_ms[48], interval_ms[32], schedule_s[32], repeat_req[1],
  // owner_tag[16], signal_tag[16], timer_id[32], zero fill
  input  logic [183:0] in_tdata,
  // bits from 0: command[3]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // bits from 0: ok[1], fired_id[32], fired_owner[16], fired_signal[16], zero fill
  output logic [71:0]  out_tdata,
  // bits from 0: kind[2]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [ID_MAX_W-1:0] ID_MASK =
    (ID_WIDTH >= ID_MAX_W) ? {ID_MAX_W{1'b1}} : ((ID_MAX_W'(1) << ID_WIDTH) - ID_MAX_W'(1));
  localparam logic [TAG_MAX_W-1:0] TAG_MASK =
    (TAG_WIDTH >= TAG_MAX_W) ? {TAG_MAX_W{1'b1}} : ((TAG_MAX_W'(1) << TAG_WIDTH) - TAG_MAX_W'(1));

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_WAVE, S_DONE, S_COMMIT} state_t;

  state_t state_r;

  // captured command
  logic [2:0]        cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [IV_W-1:0]   iv_r;
  logic [31:0]       sch_r;
  logic              rep_r;
  logic [15:0]       own_r, sig_r;
  logic [31:0]       id_r;
  logic [TIME_W-1:0] dl_new_r;
  logic              start_r;

  // pending fired result, held until the next wave shows whether it is last
  logic                 pend_v_r;
  logic [IDX_W-1:0]     pend_idx_r;
  logic [ID_WIDTH-1:0]  pend_id_r;
  logic [TAG_WIDTH-1:0] pend_own_r, pend_sig_r;

  // result register
  logic        out_v_r;
  logic [1:0]  out_kind_r;
  logic        out_ok_r;
  logic [31:0] out_id_r;
  logic [15:0] out_own_r, out_sig_r;
  logic        out_last_r;

  bcast_t bc;
  fire_t  fire;
  logic   out_free;

  ctl_t                 c_ctl [SLOTS+1];
  logic [TIME_W-1:0]    c_dl  [SLOTS+1];
  logic [IDX_W-1:0]     c_idx [SLOTS+1];
  logic [ID_WIDTH-1:0]  c_id  [SLOTS+1];
  logic [TAG_WIDTH-1:0] c_own [SLOTS+1];
  logic [TAG_WIDTH-1:0] c_sig [SLOTS+1];

  logic [TIME_W:0]   rel_sum;
  logic [41:0]       abs_prod;
  logic [ID_MAX_W-1:0]  pend_id_ext;
  logic [TAG_MAX_W-1:0] pend_own_ext, pend_sig_ext;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_v_r || out_tready;

  assign bc.cmd    = cmd_r;
  assign bc.now    = now_r;
  assign bc.dl_new = dl_new_r;
  assign bc.iv     = iv_r;
  assign bc.rep    = rep_r;
  assign bc.own    = TAG_MAX_W'(own_r) & TAG_MASK;
  assign bc.sig    = TAG_MAX_W'(sig_r) & TAG_MASK;
  assign bc.id     = ID_MAX_W'(id_r) & ID_MASK;

  assign fire.en  = (state_r == S_COMMIT);
  assign fire.idx = IDX_MAX_W'(pend_idx_r);

  // deadline of a new timer or a new interval; the relative sum saturates at the top of the time range
  assign rel_sum  = {1'b0, now_r} + {{(TIME_W + 1 - IV_W){1'b0}}, iv_r};
  assign abs_prod = 42'(sch_r) * 42'(MS_PER_S);

  assign pend_id_ext  = ID_MAX_W'(pend_id_r);
  assign pend_own_ext = TAG_MAX_W'(pend_own_r);
  assign pend_sig_ext = TAG_MAX_W'(pend_sig_r);

  // wave seed
  assign c_ctl[0].v     = start_r;
  assign c_ctl[0].found = 1'b0;
  assign c_dl[0]        = '0;
  assign c_idx[0]       = '0;
  assign c_id[0]        = '0;
  assign c_own[0]       = '0;
  assign c_sig[0]       = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tq_cell #(
      .IDX       (g),
      .IDX_W     (IDX_W),
      .ID_WIDTH  (ID_WIDTH),
      .TAG_WIDTH (TAG_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .bc    (bc),
      .fire  (fire),
      .ci    (c_ctl[g]),
      .dl_i  (c_dl[g]),
      .idx_i (c_idx[g]),
      .id_i  (c_id[g]),
      .own_i (c_own[g]),
      .sig_i (c_sig[g]),
      .co    (c_ctl[g+1]),
      .dl_o  (c_dl[g+1]),
      .idx_o (c_idx[g+1]),
      .id_o  (c_id[g+1]),
      .own_o (c_own[g+1]),
      .sig_o (c_sig[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            now_r   <= in_tdata[47:0];
            iv_r    <= in_tdata[79:48];
            sch_r   <= in_tdata[111:80];
            rep_r   <= in_tdata[112];
            own_r   <= in_tdata[128:113];
            sig_r   <= in_tdata[144:129];
            id_r    <= in_tdata[176:145];
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          if (cmd_r == CMD_ADD_ABS) begin
            dl_new_r <= TIME_W'(abs_prod);
          end else begin
            dl_new_r <= rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];
          end
          start_r <= 1'b1;
          state_r <= S_WAVE;
        end
        S_WAVE: begin
          if (c_ctl[SLOTS].v) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd_r == CMD_TICK) begin
            if (c_ctl[SLOTS].found) begin
              if (!pend_v_r || out_free) begin
                if (pend_v_r) begin
                  out_v_r    <= 1'b1;
                  out_kind_r <= KIND_FIRED;
                  out_ok_r   <= 1'b1;
                  out_id_r   <= pend_id_ext[31:0];
                  out_own_r  <= pend_own_ext[15:0];
                  out_sig_r  <= pend_sig_ext[15:0];
                  out_last_r <= 1'b0;
                end
                pend_v_r   <= 1'b1;
                pend_idx_r <= c_idx[SLOTS];
                pend_id_r  <= c_id[SLOTS];
                pend_own_r <= c_own[SLOTS];
                pend_sig_r <= c_sig[SLOTS];
                state_r    <= S_COMMIT;
              end
            end else if (out_free) begin
              // nothing more due: the held result, or an idle result when none fired, closes the tick
              out_v_r    <= 1'b1;
              out_kind_r <= pend_v_r ? KIND_FIRED : KIND_IDLE;
              out_ok_r   <= pend_v_r;
              out_id_r   <= pend_v_r ? pend_id_ext[31:0] : '0;
              out_own_r  <= pend_v_r ? pend_own_ext[15:0] : '0;
              out_sig_r  <= pend_v_r ? pend_sig_ext[15:0] : '0;
              out_last_r <= 1'b1;
              pend_v_r   <= 1'b0;
              state_r    <= S_IDLE;
            end
          end else if (out_free) begin
            out_v_r    <= 1'b1;
            out_kind_r <= KIND_ACK;
            out_ok_r   <= c_ctl[SLOTS].found;
            out_id_r   <= ((cmd_r == CMD_ADD_REL) || (cmd_r == CMD_ADD_ABS)) ?
                          bc.id[31:0] : '0;
            out_own_r  <= '0;
            out_sig_r  <= '0;
            out_last_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_COMMIT: begin
          // the fired slot updates at this edge; the next wave starts after it
          start_r <= 1'b1;
          state_r <= S_WAVE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_sig_r, out_own_r, out_id_r, out_ok_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_fire_single: assert property (@(posedge clk) disable iff (!rst_n)
    fire.en |=> !fire.en && start_r)
    else $error("fire commit not followed by a fresh wave");

  a_tail_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
    c_ctl[SLOTS].v |-> (state_r == S_WAVE))
    else $error("wave reached chain end outside wave state");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_PREP))
    else $error("accepted item did not start processing");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("fired result left pending at idle");

  a_commit_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fire.en |-> pend_v_r && (cmd_r == CMD_TICK))
    else $error("commit without a pending fired timer");
`endif

endmodule
